// ===== design/svpwm_pkg.sv =====
// Shared widths, constants and types for the min-max injection SVPWM block.
`default_nettype none

package svpwm_pkg;

  // Port widths.
  localparam int unsigned IN_W   = 16;
  localparam int unsigned BUS_W  = 16;
  localparam int unsigned DUTY_W = 16;

  // Internal arithmetic widths: phase voltages in Q.24 need 33 bits signed.
  localparam int unsigned PH_W   = 34;
  localparam int unsigned SUM_W  = PH_W + 1;
  localparam int unsigned MAG_W  = SUM_W - 2;
  localparam int unsigned NUM_W  = MAG_W + 1;

  // Quotients of 2^15 or more always saturate, so only 15 bits are resolved.
  localparam int unsigned QUO_W      = 15;
  localparam int unsigned REM_W      = BUS_W + QUO_W;
  localparam int unsigned DIV_STAGES = QUO_W;

  // Fixed-point constants.
  localparam logic signed [17:0] SQRT3_HALF = 18'sd56756;
  localparam logic [BUS_W-1:0]   BUS_FLOOR  = 16'd768;
  localparam logic [DUTY_W-1:0]  DUTY_HALF  = 16'd32768;
  localparam logic [DUTY_W-1:0]  DUTY_MAX   = 16'hFFFF;
  localparam logic [DUTY_W-1:0]  DUTY_MIN   = 16'h0000;

  // Sign and saturation flags that travel with each phase through the divider.
  typedef struct packed {
    logic neg;
    logic sat;
  } lane_flags_t;

endpackage

`default_nettype wire

// ===== design/svpwm_div.sv =====
// Pipelined restoring divider lane: one quotient bit per register stage.
`default_nettype none

module svpwm_div
  import svpwm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [REM_W-1:0]  num_i,
  input  wire logic [BUS_W-1:0]  den_i,
  input  wire lane_flags_t       flags_i,
  output logic      [QUO_W-1:0]  quo_o,
  output lane_flags_t            flags_o
);

  logic [REM_W-1:0] rem_q [DIV_STAGES];
  logic [BUS_W-1:0] den_q [DIV_STAGES];
  logic [QUO_W-1:0] quo_q [DIV_STAGES];
  lane_flags_t      flg_q [DIV_STAGES];

  // Each stage tries to subtract the divisor shifted to its own bit weight.
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int unsigned K = QUO_W - 1 - j;

    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] trial;
    logic [BUS_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    lane_flags_t      flg_in;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign flg_in = flags_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
      assign flg_in = flg_q[j-1];
    end

    assign trial = REM_W'(den_in) << K;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? (rem_in - trial) : rem_in;
        den_q[j] <= den_in;
        quo_q[j] <= quo_in | (QUO_W'(ge) << K);
        flg_q[j] <= flg_in;
      end
    end
  end

  assign quo_o   = quo_q[DIV_STAGES-1];
  assign flags_o = flg_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== design/svpwm_min_max_injection.sv =====
// Throughput: one word per cycle while in_ready_o is high; the 15-stage divider lanes,
// one quotient bit per stage, set the depth. A one-word skid register lets the pipeline
// keep taking words while a finished result waits, so in_ready_o only falls when it is
// full. Reset clears the stage valid bits and the skid flag; no data is cleared.
`default_nettype none

module svpwm_min_max_injection
  import svpwm_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [IN_W-1:0]   volt_alpha_i,
  input  wire logic signed [IN_W-1:0]   volt_beta_i,
  input  wire logic        [BUS_W-1:0]  bus_voltage_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic             [DUTY_W-1:0] duty_phase_a_o,
  output logic             [DUTY_W-1:0] duty_phase_b_o,
  output logic             [DUTY_W-1:0] duty_phase_c_o
);

  localparam int unsigned NSTAGE = 5 + DIV_STAGES + 1;

  logic              en;
  logic [NSTAGE-1:0] vld_q;
  logic              skid_full_q;

  // The whole pipeline moves unless the skid register is occupied.
  assign en         = !skid_full_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTAGE-2:0], in_valid_i};
    end
  end

  // Stage 1: floor the bus voltage and form the beta product.
  logic signed [IN_W-1:0] al1_q;
  logic signed [PH_W-1:0] prod1_d;
  logic signed [PH_W-1:0] prod1_q;
  logic [BUS_W-1:0]       bus1_q;

  // Both factors are sign-extended to the full phase width before the multiply.
  assign prod1_d = SQRT3_HALF * volt_beta_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      al1_q   <= volt_alpha_i;
      prod1_q <= prod1_d;
      bus1_q  <= (bus_voltage_i < BUS_FLOOR) ? BUS_FLOOR : bus_voltage_i;
    end
  end

  // Stage 2: inverse Clarke transform into three Q.24 phase voltages.
  logic signed [PH_W-1:0] alx;
  logic signed [PH_W-1:0] alh;
  logic signed [PH_W-1:0] ph2_q [3];
  logic [BUS_W-1:0]       bus2_q;

  assign alx = PH_W'(al1_q);
  assign alh = alx <<< 15;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph2_q[0] <= alx <<< 16;
      ph2_q[1] <= prod1_q - alh;
      ph2_q[2] <= -alh - prod1_q;
      bus2_q   <= bus1_q;
    end
  end

  // Stage 3: zero-sequence offset, the floored mean of the largest and smallest phase.
  logic signed [PH_W-1:0]  mx;
  logic signed [PH_W-1:0]  mn;
  logic signed [SUM_W-1:0] mm_sum;
  logic signed [PH_W-1:0]  ph3_q [3];
  logic signed [PH_W-1:0]  off3_q;
  logic [BUS_W-1:0]        bus3_q;

  always_comb begin
    mx = ph2_q[0];
    mn = ph2_q[0];
    for (int i = 1; i < 3; i++) begin
      if (ph2_q[i] > mx) begin
        mx = ph2_q[i];
      end
      if (ph2_q[i] < mn) begin
        mn = ph2_q[i];
      end
    end
    mm_sum = SUM_W'(mx) + SUM_W'(mn);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph3_q  <= ph2_q;
      off3_q <= PH_W'(mm_sum >>> 1);
      bus3_q <= bus2_q;
    end
  end

  // Stage 4: shifted phase voltages split into sign and magnitude.
  logic signed [SUM_W-1:0] v4 [3];
  logic [SUM_W-1:0]        vabs4 [3];
  logic [MAG_W-1:0]        mag4_q [3];
  logic [2:0]              neg4_q;
  logic [BUS_W-1:0]        bus4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v4[i]    = SUM_W'(ph3_q[i]) - SUM_W'(off3_q);
      vabs4[i] = v4[i][SUM_W-1] ? SUM_W'(-v4[i]) : SUM_W'(v4[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag4_q[i] <= vabs4[i][MAG_W-1:0];
        neg4_q[i] <= v4[i][SUM_W-1];
      end
      bus4_q <= bus3_q;
    end
  end

  // Stage 5: add half the divisor for rounding and flag quotients that saturate.
  logic [NUM_W-1:0] num5 [3];
  logic [NUM_W-1:0] lim5;
  logic [REM_W-1:0] num5_q [3];
  lane_flags_t      flg5_q [3];
  logic [BUS_W-1:0] bus5_q;

  always_comb begin
    lim5 = NUM_W'(bus4_q) << QUO_W;
    for (int i = 0; i < 3; i++) begin
      num5[i] = NUM_W'(mag4_q[i]) + NUM_W'(bus4_q >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num5_q[i]     <= num5[i][REM_W-1:0];
        flg5_q[i].neg <= neg4_q[i];
        flg5_q[i].sat <= (num5[i] >= lim5);
      end
      bus5_q <= bus4_q;
    end
  end

  // Three divider lanes, one per phase, sharing the floored bus voltage.
  logic [QUO_W-1:0] quo [3];
  lane_flags_t      flg [3];

  for (genvar p = 0; p < 3; p++) begin : g_lane
    svpwm_div u_div (
      .clk_i   (clk_i),
      .en_i    (en),
      .num_i   (num5_q[p]),
      .den_i   (bus5_q),
      .flags_i (flg5_q[p]),
      .quo_o   (quo[p]),
      .flags_o (flg[p])
    );
  end

  // Final stage: offset by one half and saturate to a Q0.16 duty.
  logic [DUTY_W-1:0] duty_d [3];
  logic [DUTY_W-1:0] duty_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (flg[i].sat) begin
        duty_d[i] = flg[i].neg ? DUTY_MIN : DUTY_MAX;
      end else if (flg[i].neg) begin
        duty_d[i] = DUTY_HALF - DUTY_W'(quo[i]);
      end else begin
        duty_d[i] = DUTY_HALF + DUTY_W'(quo[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      duty_q <= duty_d;
    end
  end

  // Skid register: catches the last-stage word when the consumer stalls.
  logic [DUTY_W-1:0] skid_duty_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else if (en) begin
      skid_full_q <= vld_q[NSTAGE-1] && !out_ready_i;
    end else if (out_ready_i) begin
      skid_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NSTAGE-1] && !out_ready_i) begin
      skid_duty_q <= duty_q;
    end
  end

  assign out_valid_o    = skid_full_q || vld_q[NSTAGE-1];
  assign duty_phase_a_o = skid_full_q ? skid_duty_q[0] : duty_q[0];
  assign duty_phase_b_o = skid_full_q ? skid_duty_q[1] : duty_q[1];
  assign duty_phase_c_o = skid_full_q ? skid_duty_q[2] : duty_q[2];

endmodule

`default_nettype wire
